// ===== hdl/bcdf_pkg.sv =====
// Shared types, constants and helper functions for the BUFR/CREX message deframer.
`timescale 1ns / 1ps

package bcdf_pkg;

  typedef enum logic [3:0] {
    PhHunt = 4'b0001,
    PhHdr  = 4'b0010,
    PhBody = 4'b0100,
    PhText = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    StData  = 2'd0,
    StShort = 2'd1,
    StTrunc = 2'd2,
    StLong  = 2'd3
  } status_e;

  // register index = paddr[2]
  localparam logic RegFormatMode   = 1'b0;
  localparam logic RegMaxTextLength = 1'b1;

  localparam logic        FormatResetVal = 1'b0;
  localparam logic [15:0] MaxLenResetVal = 16'd15360;

  localparam logic [7:0]  CharPlus  = 8'h2B;
  localparam logic [7:0]  CharCr    = 8'h0D;
  localparam logic [7:0]  CharLf    = 8'h0A;
  localparam logic [7:0]  CharSeven = 8'h37;

  localparam logic [2:0]  BufrMarkLen = 3'd4;
  localparam logic [2:0]  CrexMarkLen = 3'd6;
  localparam logic [3:0]  CrexEndDone = 4'd8;
  localparam logic [23:0] MinBufrLen  = 24'd12;
  localparam logic [23:0] BufrHdrLen  = 24'd8;
  localparam logic [3:0]  BufrHdrBurst = 4'd8;
  localparam logic [3:0]  CrexPfxBurst = 4'd6;

  typedef struct packed {
    logic        format_mode;
    logic [15:0] max_text_length;
    logic        mode_wr;
  } cfg_t;

  // results caused by one request: up to eight bytes sharing flags and status
  typedef struct packed {
    logic [3:0]      count;
    logic [7:0][7:0] bytes;
    logic            first;
    logic            last;
    logic [1:0]      status;
  } burst_t;

  function automatic logic [7:0] marker_byte(input logic crex, input logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    if (crex) begin
      case (idx)
        3'd0:    r = 8'h43;
        3'd1:    r = 8'h52;
        3'd2:    r = 8'h45;
        3'd3:    r = 8'h58;
        3'd4:    r = CharPlus;
        3'd5:    r = CharPlus;
        default: r = 8'h00;
      endcase
    end else begin
      case (idx)
        3'd0:    r = 8'h42;
        3'd1:    r = 8'h55;
        3'd2:    r = 8'h46;
        3'd3:    r = 8'h52;
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  // CREX end marker tracker: "++", CR/LF run, "7777"
  function automatic logic [3:0] end_next(input logic [3:0] g, input logic [7:0] c);
    logic plus;
    logic crlf;
    logic [3:0] r;
    plus = (c == CharPlus);
    crlf = (c == CharCr) || (c == CharLf);
    r = plus ? 4'd1 : 4'd0;
    case (g)
      4'd0, 4'd1: begin
        r = plus ? g + 4'd1 : 4'd0;
      end
      4'd2: begin
        if (crlf) r = 4'd3;
        else r = plus ? 4'd2 : 4'd0;
      end
      4'd3: begin
        if (crlf) r = 4'd3;
        else if (c == CharSeven) r = 4'd5;
        else r = plus ? 4'd1 : 4'd0;
      end
      4'd5, 4'd6, 4'd7: begin
        if (c == CharSeven) r = g + 4'd1;
        else r = plus ? 4'd1 : 4'd0;
      end
      default: r = plus ? 4'd1 : 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/bcdf_in_if.sv =====
// Input byte channel: valid/ready with one raw stream byte per request.
`timescale 1ns / 1ps

interface bcdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, data_byte, stream_end, input ready);
  modport sink (input valid, data_byte, stream_end, output ready);
endinterface

// ===== hdl/bcdf_out_if.sv =====
// Result channel: valid/ready with one message byte or error per request.
`timescale 1ns / 1ps

interface bcdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       message_first;
  logic       message_last;
  logic [1:0] status;

  modport source (output valid, out_byte, message_first, message_last, status, input ready);
  modport sink (input valid, out_byte, message_first, message_last, status, output ready);
endinterface

// ===== hdl/bcdf_cfg.sv =====
// APB-style configuration registers: format mode and CREX length limit.
`timescale 1ns / 1ps

module bcdf_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output bcdf_pkg::cfg_t    cfg_o
);

  logic        mode_q, mode_d;
  logic [15:0] max_q, max_d;
  logic        wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    mode_d = mode_q;
    max_d  = max_q;
    if (wr) begin
      case (paddr[2])
        bcdf_pkg::RegFormatMode:    mode_d = pwdata[0];
        bcdf_pkg::RegMaxTextLength: max_d  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bcdf_pkg::RegFormatMode:    prdata = {31'd0, mode_q};
      bcdf_pkg::RegMaxTextLength: prdata = {16'd0, max_q};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bcdf_pkg::FormatResetVal;
      max_q  <= bcdf_pkg::MaxLenResetVal;
    end else begin
      mode_q <= mode_d;
      max_q  <= max_d;
    end
  end

  assign cfg_o.format_mode     = mode_q;
  assign cfg_o.max_text_length = max_q;
  assign cfg_o.mode_wr         = wr && (paddr[2] == bcdf_pkg::RegFormatMode);

endmodule

// ===== hdl/bcdf_core.sv =====
// Framing state machine: marker hunt, header hold, body and text counting.
`timescale 1ns / 1ps

module bcdf_core #(
  parameter int TEXT_COUNT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bcdf_pkg::cfg_t       cfg_i,
  input  logic                 fire_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 stream_end_i,
  output bcdf_pkg::burst_t     burst_o
);

  localparam int CmpW = (TEXT_COUNT_BITS > 16) ? TEXT_COUNT_BITS : 16;

  bcdf_pkg::phase_e        phase_q, phase_d;
  logic [3:0]              mp_q, mp_d;
  logic [7:0][7:0]         held_q, held_d;
  logic [23:0]             bl_q, bl_d;
  logic [TEXT_COUNT_BITS-1:0] tc_q, tc_d;

  logic                    crex;
  logic [2:0]              mlen;
  logic [2:0]              p;
  logic [23:0]             hdr_len;
  logic [23:0]             bl_dec;
  logic [3:0]              g_next;
  logic                    over;

  assign crex    = cfg_i.format_mode;
  assign mlen    = crex ? bcdf_pkg::CrexMarkLen : bcdf_pkg::BufrMarkLen;
  assign hdr_len = {held_q[4], held_q[5], held_q[6]};
  assign bl_dec  = (bl_q != 24'd0) ? bl_q - 24'd1 : 24'd0;
  assign g_next  = bcdf_pkg::end_next(mp_q, data_byte_i);
  assign over    = CmpW'(tc_q) >= CmpW'(cfg_i.max_text_length);

  always_comb begin
    phase_d = phase_q;
    mp_d    = mp_q;
    held_d  = held_q;
    bl_d    = bl_q;
    tc_d    = tc_q;
    p       = (mp_q >= {1'b0, mlen}) ? 3'd0 : mp_q[2:0];
    burst_o = '0;

    if (stream_end_i) begin
      if (phase_q != bcdf_pkg::PhHunt) begin
        burst_o.count  = 4'd1;
        burst_o.last   = 1'b1;
        burst_o.status = bcdf_pkg::StTrunc;
      end
      phase_d = bcdf_pkg::PhHunt;
      mp_d    = 4'd0;
      bl_d    = 24'd0;
      tc_d    = '0;
    end else begin
      case (phase_q)
        bcdf_pkg::PhHunt: begin
          if (data_byte_i == bcdf_pkg::marker_byte(crex, p)) p = p + 3'd1;
          else p = (data_byte_i == bcdf_pkg::marker_byte(crex, 3'd0)) ? 3'd1 : 3'd0;
          if (p == mlen) begin
            if (crex) begin
              burst_o.count = bcdf_pkg::CrexPfxBurst;
              burst_o.first = 1'b1;
              for (int i = 0; i < 6; i++) begin
                burst_o.bytes[i] = bcdf_pkg::marker_byte(1'b1, 3'(i));
              end
              tc_d    = TEXT_COUNT_BITS'(6);
              mp_d    = 4'd0;
              phase_d = bcdf_pkg::PhText;
            end else begin
              for (int i = 0; i < 4; i++) begin
                held_d[i] = bcdf_pkg::marker_byte(1'b0, 3'(i));
              end
              mp_d    = 4'd4;
              phase_d = bcdf_pkg::PhHdr;
            end
          end else begin
            mp_d = {1'b0, p};
          end
        end
        bcdf_pkg::PhHdr: begin
          held_d[mp_q[2:0]] = data_byte_i;
          mp_d = mp_q + 4'd1;
          if (mp_q[2:0] == 3'd7) begin
            if (hdr_len < bcdf_pkg::MinBufrLen) begin
              burst_o.count  = 4'd1;
              burst_o.last   = 1'b1;
              burst_o.status = bcdf_pkg::StShort;
              phase_d = bcdf_pkg::PhHunt;
              mp_d    = 4'd0;
              bl_d    = 24'd0;
              tc_d    = '0;
            end else begin
              burst_o.count = bcdf_pkg::BufrHdrBurst;
              burst_o.first = 1'b1;
              for (int i = 0; i < 7; i++) begin
                burst_o.bytes[i] = held_q[i];
              end
              burst_o.bytes[7] = data_byte_i;
              bl_d    = hdr_len - bcdf_pkg::BufrHdrLen;
              mp_d    = 4'd0;
              phase_d = bcdf_pkg::PhBody;
            end
          end
        end
        bcdf_pkg::PhBody: begin
          burst_o.count    = 4'd1;
          burst_o.bytes[0] = data_byte_i;
          burst_o.last     = (bl_dec == 24'd0);
          bl_d = bl_dec;
          if (bl_dec == 24'd0) begin
            phase_d = bcdf_pkg::PhHunt;
            mp_d    = 4'd0;
            tc_d    = '0;
          end
        end
        bcdf_pkg::PhText: begin
          burst_o.count = 4'd1;
          if (over) begin
            burst_o.last   = 1'b1;
            burst_o.status = bcdf_pkg::StLong;
            phase_d = bcdf_pkg::PhHunt;
            mp_d    = 4'd0;
            bl_d    = 24'd0;
            tc_d    = '0;
          end else begin
            burst_o.bytes[0] = data_byte_i;
            burst_o.last     = (g_next == bcdf_pkg::CrexEndDone);
            mp_d = g_next;
            if (tc_q != '1) tc_d = tc_q + TEXT_COUNT_BITS'(1);
            if (g_next == bcdf_pkg::CrexEndDone) begin
              phase_d = bcdf_pkg::PhHunt;
              mp_d    = 4'd0;
              bl_d    = 24'd0;
              tc_d    = '0;
            end
          end
        end
        default: begin
          phase_d = bcdf_pkg::PhHunt;
          mp_d    = 4'd0;
          bl_d    = 24'd0;
          tc_d    = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bcdf_pkg::PhHunt;
      mp_q    <= 4'd0;
      bl_q    <= 24'd0;
      tc_q    <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      mp_q    <= mp_d;
      bl_q    <= bl_d;
      tc_q    <= tc_d;
    end else if (cfg_i.mode_wr && (phase_q == bcdf_pkg::PhHunt)) begin
      mp_q <= 4'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) held_q <= held_d;
  end

endmodule

// ===== hdl/bcdf_out.sv =====
// Result register: holds one request's burst and hands it out a byte per cycle while ready.
`timescale 1ns / 1ps

module bcdf_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  bcdf_pkg::burst_t   burst_i,
  output logic               can_load_o,
  bcdf_out_if.source         out_o
);

  logic [3:0]      count_q;
  logic [2:0]      pos_q;
  logic [7:0][7:0] bytes_q;
  logic            first_q;
  logic            last_q;
  logic [1:0]      status_q;
  logic            last_beat;
  logic            out_fire;

  assign out_o.valid = (count_q != 4'd0);
  assign last_beat   = ({1'b0, pos_q} == count_q - 4'd1);
  assign out_fire    = out_o.valid && out_o.ready;
  assign can_load_o  = !out_o.valid || (out_fire && last_beat);

  assign out_o.out_byte      = bytes_q[pos_q];
  assign out_o.message_first = first_q && (pos_q == 3'd0);
  assign out_o.message_last  = last_q && last_beat;
  assign out_o.status        = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd0;
      pos_q   <= 3'd0;
    end else if (fire_i) begin
      count_q <= burst_i.count;
      pos_q   <= 3'd0;
    end else if (out_fire) begin
      if (last_beat) count_q <= 4'd0;
      pos_q <= pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      bytes_q  <= burst_i.bytes;
      first_q  <= burst_i.first;
      last_q   <= burst_i.last;
      status_q <= burst_i.status;
    end
  end

endmodule

// ===== hdl/bufr_crex_message_deframer.sv =====
// Top level of the BUFR/CREX message deframer.
`timescale 1ns / 1ps
//
// Raw stream bytes enter on in_i (valid/ready); stream_end marks the end of
// a stream and its data byte is ignored. Message bytes and error results
// leave on out_o with first/last flags and a status code. The APB port
// selects BUFR or CREX framing and sets the CREX length limit; write it only
// while the block is idle.
// Latency: a request's first result is presented the cycle after it is taken.
// Throughput: one byte per cycle while out_o is ready and each request causes
// at most one result; a completed BUFR header emits eight results and a CREX
// prefix six, so the request after them waits for the output register to
// drain, one result per cycle; it reloads in the cycle its last result goes.
// When out_o is stalled the held result stays and in_i.ready falls once the
// register holds a result that is not being taken.
// Reset puts the framer in the hunt for a start marker, BUFR mode, with a
// CREX limit of 15360 bytes, and empties the result register.
//

module bufr_crex_message_deframer #(
  parameter int TEXT_COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcdf_in_if.sink     in_i,
  bcdf_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bcdf_pkg::cfg_t   cfg;
  bcdf_pkg::burst_t burst;
  logic             can_load;
  logic             in_fire;

  assign in_i.ready = can_load;
  assign in_fire    = in_i.valid && can_load;

  bcdf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bcdf_core #(
    .TEXT_COUNT_BITS (TEXT_COUNT_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .fire_i       (in_fire),
    .data_byte_i  (in_i.data_byte),
    .stream_end_i (in_i.stream_end),
    .burst_o      (burst)
  );

  bcdf_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .burst_i    (burst),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule
